/* hw/rtl/ppp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

    localparam int MAX_ITEMS  = 128;
    localparam int VALUE_BITS = 16;

    // widths fixed by the item fields
    localparam int FIELD_W = 16;
    localparam int SLOT_W  = 7;

    // value bits actually used
    localparam int VAL_W = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
    // trial divisor: covers sqrt of the largest value plus one odd step
    localparam int DIV_W = (VAL_W + 1) / 2 + 1;
    // running square of the divisor
    localparam int SQ_W = VAL_W + 2;
    // list counts hold 0 .. MAX_ITEMS
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    // bit counter of the serial remainder unit
    localparam int BIT_CNT_W = $clog2(VAL_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic divisible;
    } t_div_rsp;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [CNT_W-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/parity_prime_partitioner_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------------
// input    | i_in_valid / o_in_ready   | i_value, i_first
// output   | o_out_valid / i_out_ready | o_value_out, o_is_odd, o_is_prime,
//          |                           | o_parity_slot, o_prime_slot, o_list_full
//
// one item at a time; 0, 1 and even values are classed without any division
// odd values run one serial remainder per odd divisor d from 3 with d*d <= value,
// stopping early at the first divisor that leaves no remainder
// the next item is taken while a finished result waits in the output register
// synchronous active-low reset clears the counts and the sequencer

module parity_prime_partitioner_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ppp_pkg::FIELD_W-1:0]   i_value,
    input  wire logic                          i_first,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ppp_pkg::FIELD_W-1:0]        o_value_out,
    output logic                               o_is_odd,
    output logic                               o_is_prime,
    output logic [ppp_pkg::SLOT_W-1:0]         o_parity_slot,
    output logic [ppp_pkg::SLOT_W-1:0]         o_prime_slot,
    output logic                               o_list_full
);
    import ppp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic             w_accept;
    logic             w_seq_idle;
    logic             w_seq_done;
    logic             w_prime;
    logic [VAL_W-1:0] w_value;
    logic             w_load;

    logic             r_first;
    logic [CNT_W-1:0] r_even_cnt;
    logic [CNT_W-1:0] r_odd_cnt;
    logic [CNT_W-1:0] r_prime_cnt;
    logic             r_out_valid;

    logic [FIELD_W-1:0] r_value_out;
    logic               r_is_odd;
    logic               r_is_prime;
    logic [SLOT_W-1:0]  r_parity_slot;
    logic [SLOT_W-1:0]  r_prime_slot;
    logic               r_list_full;

    logic [CNT_W-1:0] w_par_base, w_par_next, w_par_slot;
    logic [CNT_W-1:0] w_pr_base, w_pr_next, w_pr_slot;
    logic             w_par_full, w_pr_full;

    assign o_in_ready = w_seq_idle;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_seq_done && (!r_out_valid || i_out_ready);

    ppp_prime_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_value   (i_value[VAL_W-1:0]),
        .i_ack     (w_load),
        .o_idle    (w_seq_idle),
        .o_done    (w_seq_done),
        .o_prime   (w_prime),
        .o_value   (w_value),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp)
    );

    ppp_rem_serial u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // slot claim with saturation; a first item starts from empty lists
    always_comb begin
        if (r_first) begin
            w_par_base = '0;
            w_pr_base  = '0;
        end else begin
            w_par_base = w_value[0] ? r_odd_cnt : r_even_cnt;
            w_pr_base  = r_prime_cnt;
        end
        w_par_full = (w_par_base >= CNT_MAX);
        w_pr_full  = (w_pr_base >= CNT_MAX);
        w_par_slot = w_par_full ? CNT_MAX - 1'b1 : w_par_base;
        w_pr_slot  = w_pr_full ? CNT_MAX - 1'b1 : w_pr_base;
        w_par_next = w_par_full ? CNT_MAX : w_par_base + 1'b1;
        w_pr_next  = w_pr_full ? CNT_MAX : w_pr_base + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_cnt  <= '0;
            r_odd_cnt   <= '0;
            r_prime_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_value[0]) begin
                    r_odd_cnt  <= w_par_next;
                    r_even_cnt <= r_first ? '0 : r_even_cnt;
                end else begin
                    r_even_cnt <= w_par_next;
                    r_odd_cnt  <= r_first ? '0 : r_odd_cnt;
                end
                if (w_prime) begin
                    r_prime_cnt <= w_pr_next;
                end else begin
                    r_prime_cnt <= r_first ? '0 : r_prime_cnt;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= i_first;
        end
        if (w_load) begin
            r_value_out   <= FIELD_W'(w_value);
            r_is_odd      <= w_value[0];
            r_is_prime    <= w_prime;
            r_parity_slot <= to_slot(w_par_slot);
            r_prime_slot  <= w_prime ? to_slot(w_pr_slot) : '0;
            r_list_full   <= w_par_full || (w_prime && w_pr_full);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_is_odd      = r_is_odd;
    assign o_is_prime    = r_is_prime;
    assign o_parity_slot = r_parity_slot;
    assign o_prime_slot  = r_prime_slot;
    assign o_list_full   = r_list_full;

    a_counts_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_even_cnt <= CNT_MAX && r_odd_cnt <= CNT_MAX && r_prime_cnt <= CNT_MAX)
        else $error("list count beyond its limit");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && w_seq_done))
        else $error("input ready while a result is pending");

    a_nonprime_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_is_prime |-> r_prime_slot == '0)
        else $error("prime slot set for a non-prime item");

    a_prime_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_load) && $past(w_prime) && !$past(r_first) && !$past(w_pr_full)
            |-> r_prime_cnt == $past(r_prime_cnt) + 1'b1)
        else $error("prime count did not advance");

endmodule

`default_nettype wire

/* hw/rtl/ppp_rem_serial.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppp_rem_serial (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ppp_pkg::t_div_req i_req,
    output ppp_pkg::t_div_rsp      o_rsp
);
    import ppp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_shift;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W-1:0] n_rem;

    // one dividend bit per cycle, msb first, restoring step
    always_comb begin
        w_trial = {r_rem, r_shift[VAL_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_trial = w_trial - {1'b0, r_div};
        end
        n_rem = w_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= BIT_CNT_W'(VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == BIT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_shift <= i_req.dividend;
            r_div   <= i_req.divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[VAL_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.divisible = (r_rem == '0);

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_req.start) |-> r_rem < r_div)
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

/* hw/rtl/ppp_prime_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppp_prime_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ppp_pkg::VAL_W-1:0]   i_value,
    input  wire logic                        i_ack,
    output logic                             o_idle,
    output logic                             o_done,
    output logic                             o_prime,
    output logic [ppp_pkg::VAL_W-1:0]        o_value,
    output ppp_pkg::t_div_req                o_div_req,
    input  wire ppp_pkg::t_div_rsp           i_div_rsp
);
    import ppp_pkg::*;

    t_seq_state       r_state, n_state;
    logic [VAL_W-1:0] r_value, n_value;
    logic [DIV_W-1:0] r_d, n_d;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic             r_prime, n_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_prime <= n_prime;
    end

    always_comb begin
        n_state  = r_state;
        n_value  = r_value;
        n_d      = r_d;
        n_sq     = r_sq;
        n_prime  = r_prime;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_value;
        o_div_req.divisor  = r_d;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_value;
                    n_d     = DIV_W'(3);
                    n_sq    = SQ_W'(9);
                    // values below two and even values other than two fall out at once
                    if (i_value < VAL_W'(2)) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else if (i_value == VAL_W'(2)) begin
                        n_prime = 1'b1;
                        n_state = S_DONE;
                    end else if (!i_value[0]) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > SQ_W'(r_value)) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_div_req.start = 1'b1;
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.divisible) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        // odd divisors only: (d+2)^2 = d^2 + 4d + 4
                        n_d     = r_d + DIV_W'(2);
                        n_sq    = r_sq + SQ_W'({r_d, 2'b00}) + SQ_W'(4);
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_prime = r_prime;
    assign o_value = r_value;

endmodule

`default_nettype wire

/* bench/parity_prime_partitioner_top_test.sv */
`timescale 1ns / 1ps

module parity_prime_partitioner_top_test;

    localparam int IDLE_LIMIT = 25000;
    localparam int SETTLE_CYCLES = 100;
    localparam int FILL_ITEMS = 130;
    localparam int QUIET_TAIL = 30;

    typedef struct packed {
        logic [ppp_pkg::FIELD_W-1:0] value;
        logic                        odd;
        logic                        prime;
        logic [ppp_pkg::SLOT_W-1:0]  par_slot;
        logic [ppp_pkg::SLOT_W-1:0]  prm_slot;
        logic                        full;
    } class_result_t;

    typedef struct {
        logic [ppp_pkg::FIELD_W-1:0] value;
        logic                        first;
        bit                          typed;
        class_result_t               want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [ppp_pkg::FIELD_W-1:0] i_value = '0;
    logic i_first = 1'b0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic [ppp_pkg::FIELD_W-1:0] o_value_out;
    logic o_is_odd;
    logic o_is_prime;
    logic [ppp_pkg::SLOT_W-1:0] o_parity_slot;
    logic [ppp_pkg::SLOT_W-1:0] o_prime_slot;
    logic o_list_full;

    parity_prime_partitioner_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_first       (i_first),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value_out   (o_value_out),
        .o_is_odd      (o_is_odd),
        .o_is_prime    (o_is_prime),
        .o_parity_slot (o_parity_slot),
        .o_prime_slot  (o_prime_slot),
        .o_list_full   (o_list_full)
    );

    always #6 i_clk = ~i_clk;

    // running list counts of the current set
    int even_seen = 0;
    int odd_seen = 0;
    int prime_seen = 0;

    class_result_t pending_results[$];
    stim_row_t directed_rows[$];

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int primes_checked = 0;
    int full_checked = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit idle_on = 1'b0;
    bit stall_on = 1'b0;

    function automatic bit trial_prime(input int unsigned v);
        int unsigned d;
        if (v < 2) begin
            return 1'b0;
        end
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic class_result_t classify_and_count(
        input logic [ppp_pkg::FIELD_W-1:0] raw,
        input logic first
    );
        class_result_t r;
        int unsigned v;
        int cnt;
        int slot;
        r = '0;
        v = int'(raw) & ((1 << ppp_pkg::VAL_W) - 1);
        if (first) begin
            even_seen = 0;
            odd_seen = 0;
            prime_seen = 0;
        end
        r.value = v[ppp_pkg::FIELD_W-1:0];
        r.odd = v[0];
        r.prime = trial_prime(v);

        cnt = r.odd ? odd_seen : even_seen;
        if (cnt >= ppp_pkg::MAX_ITEMS) begin
            r.full = 1'b1;
            slot = ppp_pkg::MAX_ITEMS - 1;
        end else begin
            slot = cnt;
            cnt++;
        end
        r.par_slot = slot[ppp_pkg::SLOT_W-1:0];
        if (r.odd) begin
            odd_seen = cnt;
        end else begin
            even_seen = cnt;
        end

        if (r.prime) begin
            if (prime_seen >= ppp_pkg::MAX_ITEMS) begin
                r.full = 1'b1;
                slot = ppp_pkg::MAX_ITEMS - 1;
            end else begin
                slot = prime_seen;
                prime_seen++;
            end
            r.prm_slot = slot[ppp_pkg::SLOT_W-1:0];
        end
        return r;
    endfunction

    function automatic int unsigned pick_small_prime();
        int unsigned v;
        v = $urandom_range(2, 600);
        while (!trial_prime(v)) begin
            v = $urandom_range(2, 600);
        end
        return v;
    endfunction

    task automatic add_row(
        input int unsigned v, input bit f, input bit typed,
        input bit odd, input bit prime, input int ps, input int pr, input bit full
    );
        stim_row_t row;
        row.value = v[ppp_pkg::FIELD_W-1:0];
        row.first = f;
        row.typed = typed;
        row.want.value = v[ppp_pkg::FIELD_W-1:0];
        row.want.odd = odd;
        row.want.prime = prime;
        row.want.par_slot = ps[ppp_pkg::SLOT_W-1:0];
        row.want.prm_slot = pr[ppp_pkg::SLOT_W-1:0];
        row.want.full = full;
        directed_rows.push_back(row);
    endtask

    // holds the item until taken, then records what should come back
    task automatic send_item(
        input int unsigned v, input bit f, input bit typed, input class_result_t want
    );
        class_result_t predicted;
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value <= v[ppp_pkg::FIELD_W-1:0];
        i_first <= f;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted = classify_and_count(v[ppp_pkg::FIELD_W-1:0], f);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // sender goes quiet until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // odd values only, so one set of them pushes the odd list past its limit
    function automatic int unsigned random_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return $urandom_range(0, 65535) | 1;
        end else if (pick < 7) begin
            return $urandom_range(0, 1023) | 1;
        end else if (pick < 8) begin
            return pick_small_prime() | 1;
        end else if (pick < 9) begin
            pick = pick_small_prime();
            return ((pick < 256) ? pick * pick : pick) | 1;
        end
        case ($urandom_range(0, 4))
            0: return 1;
            1: return 3;
            2: return 9;
            3: return 65535;
            default: return 65521;
        endcase
    endfunction

    // output stalls in short bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        class_result_t got;
        class_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.value = o_value_out;
            got.odd = o_is_odd;
            got.prime = o_is_prime;
            got.par_slot = o_parity_slot;
            got.prm_slot = o_prime_slot;
            got.full = o_list_full;
            if (pending_results.size() == 0) begin
                log_error($sformatf("unexpected result: value %0d", got.value));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.prime) primes_checked++;
                if (want.full) full_checked++;
                if (got !== want) begin
                    log_error($sformatf({"mismatch exp/got: value %0d/%0d odd %0b/%0b ",
                        "prime %0b/%0b parity_slot %0d/%0d prime_slot %0d/%0d full %0b/%0b"},
                        want.value, got.value, want.odd, got.odd, want.prime, got.prime,
                        want.par_slot, got.par_slot, want.prm_slot, got.prm_slot,
                        want.full, got.full));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", pending_results.size());
                $display("parity_prime_partitioner_top_test: errors");
                $finish;
            end
        end
    end

    initial begin
        int i;
        class_result_t none;
        none = '0;

        // typed rows follow directly from the list rules, the rest go to the predictor
        add_row(0, 0, 1, 0, 0, 0, 0, 0);
        add_row(1, 0, 1, 1, 0, 0, 0, 0);
        add_row(2, 0, 1, 0, 1, 1, 0, 0);
        add_row(3, 0, 1, 1, 1, 1, 1, 0);
        add_row(65535, 0, 1, 1, 0, 2, 0, 0);
        add_row(65534, 0, 1, 0, 0, 2, 0, 0);
        add_row(65521, 0, 0, 0, 0, 0, 0, 0);
        add_row(4, 1, 1, 0, 0, 0, 0, 0);
        add_row(2, 1, 1, 0, 1, 0, 0, 0);
        add_row(9, 0, 0, 0, 0, 0, 0, 0);
        add_row(49, 0, 0, 0, 0, 0, 0, 0);
        add_row(121, 0, 0, 0, 0, 0, 0, 0);
        add_row(63001, 0, 0, 0, 0, 0, 0, 0);
        add_row(65025, 0, 0, 0, 0, 0, 0, 0);
        add_row(32768, 0, 0, 0, 0, 0, 0, 0);
        add_row(32749, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'h5555, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'haaaa, 0, 0, 0, 0, 0, 0, 0);
        add_row(65519, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 1, 1, 0, 0, 0, 0, 0);
        add_row(5, 0, 1, 1, 1, 0, 0, 0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        stall_on = 1'b1;
        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].value, directed_rows[k].first,
                      directed_rows[k].typed, directed_rows[k].want);
        end
        drain_results();

        // one long set of odd items so the odd list saturates
        for (i = 0; i < FILL_ITEMS; i++) begin
            if (i == FILL_ITEMS / 2) begin
                drain_results();
            end
            if (i >= FILL_ITEMS - QUIET_TAIL) begin
                idle_on = 1'b0;
                stall_on = 1'b0;
            end else if (i % 25 == 0) begin
                idle_on = $urandom_range(0, 2) != 0;
                stall_on = $urandom_range(0, 2) != 0;
            end
            send_item(random_value(), i == 0, 1'b0, none);
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d items, checked %0d results: %0d prime, %0d with a full list",
                 items_sent, results_checked, primes_checked, full_checked);
        $display("directed edges, then one long odd set that fills its list under stalls");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("parity_prime_partitioner_top_test: clean");
        end else begin
            $display("%0d errors, %0d results never arrived", error_count,
                     pending_results.size());
            $display("parity_prime_partitioner_top_test: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ppp_pkg.sv
hw/rtl/ppp_rem_serial.sv
hw/rtl/ppp_prime_seq.sv
hw/rtl/parity_prime_partitioner_top.sv
bench/parity_prime_partitioner_top_test.sv
